// File: design/hsk_pkg.sv
// ---------------------------------------------------------------------------
// hsk_pkg
// Shared types and constants of the six-key keyboard report queue: event and
// report transaction layouts, list sizes and the step control group.
// ---------------------------------------------------------------------------
package hsk_pkg;

	// List sizing
	localparam int NUM_KEYS      = 16;
	localparam int NUM_SLOTS     = 6;
	localparam int REPORT_SLOTS  = 6;
	localparam int SHOWN_SLOTS   = (NUM_SLOTS < REPORT_SLOTS) ? NUM_SLOTS : REPORT_SLOTS;
	localparam int SLOT_KEY_W    = 5;
	localparam int KEY_INDEX_W   = 4;
	localparam int CODE_W        = 8;

	// Event kinds
	localparam logic REQ_PRESS   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic                   req_type;
		logic [KEY_INDEX_W-1:0] key_index;
		logic [CODE_W-1:0]      key_code;
		logic                   is_modifier;
	} evt_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_0;
		logic [CODE_W-1:0] code_1;
		logic [CODE_W-1:0] code_2;
		logic [CODE_W-1:0] code_3;
		logic [CODE_W-1:0] code_4;
		logic [CODE_W-1:0] code_5;
		logic [CODE_W-1:0] modifier_mask;
	} rpt_t;

	// One event applied to the key list this cycle
	typedef struct packed {
		logic en;
		evt_t item;
	} step_t;

endpackage

// File: design/hsk_slot_list.sv
// ---------------------------------------------------------------------------
// hsk_slot_list
// Key list and modifier mask. Applies one event per enabled cycle: push at
// the head, remove the newest match and close the gap, or update the mask.
// Presents the report of the state after the event.
// ---------------------------------------------------------------------------
module hsk_slot_list (
	input  logic          clk,
	input  logic          arst_n,
	input  hsk_pkg::step_t step,
	output hsk_pkg::rpt_t  next_rpt
);
	import hsk_pkg::*;

	logic [SLOT_KEY_W-1:0] key_q     [NUM_SLOTS];
	code_t                 code_q    [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  valid_q;
	code_t                 mods_q;

	logic [SLOT_KEY_W-1:0] key_nxt   [NUM_SLOTS];
	code_t                 code_nxt  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  valid_nxt;
	code_t                 mods_nxt;

	logic [NUM_SLOTS-1:0]  hit;
	logic [NUM_SLOTS-1:0]  at_or_after;
	logic [SLOT_KEY_W-1:0] ev_key;
	logic                  in_range;
	code_t                 shown     [REPORT_SLOTS];

	assign ev_key   = SLOT_KEY_W'(step.item.key_index);
	assign in_range = ev_key < SLOT_KEY_W'(NUM_KEYS);

	// Find matching slots and mark everything from the first match on
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit[i] = valid_q[i] && (key_q[i] == ev_key);
		end
		at_or_after[0] = hit[0];
		for (int i = 1; i < NUM_SLOTS; i++) begin
			at_or_after[i] = at_or_after[i-1] | hit[i];
		end
	end

	// Next list and mask
	always_comb begin
		key_nxt   = key_q;
		code_nxt  = code_q;
		valid_nxt = valid_q;
		mods_nxt  = mods_q;
		if (in_range) begin
			if (step.item.is_modifier) begin
				if (step.item.req_type == REQ_RELEASE) begin
					mods_nxt = mods_q & ~step.item.key_code;
				end else begin
					mods_nxt = mods_q | step.item.key_code;
				end
			end else if (step.item.req_type == REQ_RELEASE) begin
				// close the gap behind the removed entry
				for (int i = 0; i < NUM_SLOTS - 1; i++) begin
					if (at_or_after[i]) begin
						key_nxt[i]   = key_q[i+1];
						code_nxt[i]  = code_q[i+1];
						valid_nxt[i] = valid_q[i+1];
					end
				end
				if (at_or_after[NUM_SLOTS-1]) begin
					valid_nxt[NUM_SLOTS-1] = 1'b0;
				end
			end else begin
				// push at the head, oldest drops off
				for (int i = 1; i < NUM_SLOTS; i++) begin
					key_nxt[i]   = key_q[i-1];
					code_nxt[i]  = code_q[i-1];
					valid_nxt[i] = valid_q[i-1];
				end
				key_nxt[0]   = ev_key;
				code_nxt[0]  = step.item.key_code;
				valid_nxt[0] = 1'b1;
			end
		end
	end

	// Hold the list; only occupancy and mask need reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			mods_q  <= '0;
		end else if (step.en) begin
			valid_q <= valid_nxt;
			mods_q  <= mods_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			key_q  <= key_nxt;
			code_q <= code_nxt;
		end
	end

	// Build the report, empty slots read as zero
	always_comb begin
		for (int r = 0; r < REPORT_SLOTS; r++) begin
			shown[r] = '0;
		end
		for (int r = 0; r < SHOWN_SLOTS; r++) begin
			shown[r] = valid_nxt[r] ? code_nxt[r] : '0;
		end
		next_rpt.code_0        = shown[0];
		next_rpt.code_1        = shown[1];
		next_rpt.code_2        = shown[2];
		next_rpt.code_3        = shown[3];
		next_rpt.code_4        = shown[4];
		next_rpt.code_5        = shown[5];
		next_rpt.modifier_mask = mods_nxt;
	end

endmodule

// File: design/hid_six_key_report_queue_unit.sv
// ---------------------------------------------------------------------------
// hid_six_key_report_queue_unit
// Six-key keyboard report builder with a head-insert key list.
// ---------------------------------------------------------------------------
// Usage:
//   evt channel (evt_valid, evt_stall, evt) carries key press and release
//   events; rpt channel (rpt_valid, rpt_stall, rpt) returns one report per
//   event: six slot codes, newest first, zero when empty, plus the modifier
//   mask. A transaction moves at a clock edge with valid high, stall low.
//   Path: an event is taken into the event register at the accepting edge;
//   the list update follows, and the report register loads the result once
//   the report side can advance (a stalled report holds it back).
//   Throughput: one event per cycle unless rpt_stall holds a report; the
//   list update, six key compares and one shift, lies between the registers.
//   A stalled report holds; one more event may wait in the event register,
//   and evt_stall rises only while both registers are full and rpt_stall
//   is high.
//   Reset (arst_n low) empties the list, clears the mask and drops any
//   event or report in flight.
// ---------------------------------------------------------------------------
module hid_six_key_report_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_stall,
	input  hsk_pkg::evt_t evt,
	output logic          rpt_valid,
	input  logic          rpt_stall,
	output hsk_pkg::rpt_t rpt
);
	import hsk_pkg::*;

	logic  valid_s1;
	evt_t  evt_s1;
	logic  advance;
	step_t step;
	rpt_t  next_rpt;

	assign advance   = !rpt_valid || !rpt_stall;
	assign evt_stall = valid_s1 && !advance;

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall && evt_valid) begin
			evt_s1 <= evt;
		end
	end

	assign step.en   = valid_s1 && advance;
	assign step.item = evt_s1;

	hsk_slot_list u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.next_rpt (next_rpt)
	);

	// Report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid <= 1'b0;
		end else if (advance) begin
			rpt_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			rpt <= next_rpt;
		end
	end

endmodule

// File: design/hsk_checker.sv
// ---------------------------------------------------------------------------
// hsk_checker
// Port-level checks of the report queue, bound to the top level.
// ---------------------------------------------------------------------------
module hsk_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          evt_valid,
	input logic          evt_stall,
	input hsk_pkg::evt_t evt,
	input logic          rpt_valid,
	input logic          rpt_stall,
	input hsk_pkg::rpt_t rpt
);
	import hsk_pkg::*;

	// Hold a stalled report
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_stall |=> rpt_valid && $stable(rpt))
		else $error("stalled report changed or dropped");

	// Stall events only while a report is held back
	a_evt_stall: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> rpt_valid && rpt_stall)
		else $error("event stalled while report side is free");

	// A new report follows an event transaction carried through the event register
	a_rpt_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(evt_valid && !evt_stall, 2))
		else $error("report appeared without a matching event");

endmodule

bind hid_six_key_report_queue_unit hsk_checker u_hsk_checker (.*);
